@@ rtl/sha256_pkg.sv @@
// Shared types, constants and round functions for the SHA-256 byte hasher.
package sha256_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned MsgBytesW  = 61;

  typedef enum logic {
    OP_ABSORB = 1'b0,
    OP_FINISH = 1'b1
  } op_e;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  localparam logic [255:0] InitHash = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PadMarker = 8'h80;
  localparam logic [5:0] LenOffset = 6'd56;

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k;
    case (idx)
      6'd0: k = 32'h428a2f98;   6'd1: k = 32'h71374491;
      6'd2: k = 32'hb5c0fbcf;   6'd3: k = 32'he9b5dba5;
      6'd4: k = 32'h3956c25b;   6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;   6'd7: k = 32'hab1c5ed5;
      6'd8: k = 32'hd807aa98;   6'd9: k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

@@ rtl/sha256_if.sv @@
// Valid/ready channel interfaces for input items and digest words.
interface sha256_in_if;
  logic                  valid;
  logic                  ready;
  sha256_pkg::in_item_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface sha256_out_if;
  logic                  valid;
  logic                  ready;
  sha256_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/sha256_queue.sv @@
// Small FIFO that decouples item acceptance from block processing.
module sha256_queue #(
  parameter int unsigned Depth = sha256_pkg::QueueDepth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  sha256_pkg::in_item_t push_item_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output sha256_pkg::in_item_t pop_item_o
);
  import sha256_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  in_item_t          mem_q [Depth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [PtrW:0]     cnt_q;

  assign full_o     = (cnt_q == PtrW'(0) + (PtrW+1)'(Depth));
  assign empty_o    = (cnt_q == '0);
  assign pop_item_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) mem_q[wr_q] <= push_item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i && !full_o) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i && !empty_o) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (PtrW+1)'(push_i && !full_o) - (PtrW+1)'(pop_i && !empty_o);
    end
  end
endmodule

@@ rtl/sha256_core.sv @@
// Block buffer, padding sequencer, one-round-per-cycle compression and digest output.
module sha256_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  item_valid_i,
  input  sha256_pkg::in_item_t  item_i,
  output logic                  item_pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output sha256_pkg::out_item_t out_item_o
);
  import sha256_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } state_e;

  state_e                 state_q;
  logic [6:0]             fill_q;
  logic [MsgBytesW-1:0]   msg_q;
  logic [31:0]            h_q [8];
  logic [31:0]            v_q [8];
  logic [31:0]            w_q [16];  // block words while absorbing, schedule window in rounds
  logic [5:0]             rnd_q;
  logic                   final_q;   // this compression is the last block
  logic                   extra_q;   // a length block follows this one
  logic [2:0]             widx_q;

  logic [31:0] t1, t2, s0w, s1w, wnext, wcur;
  logic [63:0] bits;
  logic [4:0]  lane_lsb;
  logic [31:0] keep_mask, marker_word;

  assign bits  = {msg_q, 3'b000};
  assign wcur  = w_q[0];
  assign s0w   = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
  assign s1w   = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
  assign wnext = s1w + w_q[9] + s0w + w_q[0];
  assign t1 = v_q[7] + (rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25)) +
              ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + round_k(rnd_q) + wcur;
  assign t2 = (rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22)) +
              ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

  // Bytes are big-endian within a word, so byte lane 0 sits in the top bits.
  assign lane_lsb    = {~fill_q[1:0], 3'b000};
  assign keep_mask   = ~(32'hffffffff >> {fill_q[1:0], 3'b000});
  assign marker_word = {24'h0, PadMarker} << lane_lsb;

  assign item_pop_o  = (state_q == ST_IDLE) && item_valid_i;
  assign out_valid_o = (state_q == ST_EMIT);
  assign out_item_o  = '{digest_word: h_q[widx_q], word_index: widx_q,
                         last_word: (widx_q == 3'd7)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
      msg_q   <= '0;
      rnd_q   <= '0;
      final_q <= 1'b0;
      extra_q <= 1'b0;
      widx_q  <= '0;
      for (int i = 0; i < 8; i++) h_q[i] <= InitHash[255-32*i -: 32];
      for (int i = 0; i < 8; i++) v_q[i] <= '0;
      for (int i = 0; i < 16; i++) w_q[i] <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (item_valid_i) begin
            if (item_i.op == OP_ABSORB) begin
              w_q[fill_q[5:2]][lane_lsb +: 8] <= item_i.data_byte;
              if (fill_q == 7'd63) begin
                fill_q  <= '0;
                msg_q   <= msg_q + MsgBytesW'(64);
                final_q <= 1'b0;
                extra_q <= 1'b0;
                for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
                rnd_q   <= '0;
                state_q <= ST_ROUND;
              end else begin
                fill_q <= fill_q + 7'd1;
              end
            end else begin
              msg_q <= msg_q + MsgBytesW'(fill_q[5:0]);
              for (int i = 0; i < 16; i++) begin
                if (i == int'(fill_q[5:2])) w_q[i] <= (w_q[i] & keep_mask) | marker_word;
                else if (i > int'(fill_q[5:2])) w_q[i] <= '0;
              end
              extra_q <= (fill_q[5:0] >= LenOffset);
              state_q <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          // The length goes into the last two words unless an extra block is needed.
          if (!extra_q) begin
            w_q[14] <= bits[63:32];
            w_q[15] <= bits[31:0];
          end
          final_q <= !extra_q;
          for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
          rnd_q   <= '0;
          state_q <= ST_ROUND;
        end
        ST_ROUND: begin
          v_q[7] <= v_q[6];
          v_q[6] <= v_q[5];
          v_q[5] <= v_q[4];
          v_q[4] <= v_q[3] + t1;
          v_q[3] <= v_q[2];
          v_q[2] <= v_q[1];
          v_q[1] <= v_q[0];
          v_q[0] <= t1 + t2;
          for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
          w_q[15] <= wnext;
          rnd_q <= rnd_q + 6'd1;
          if (rnd_q == 6'd63) state_q <= ST_ADD;
        end
        ST_ADD: begin
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
          if (extra_q) begin
            // Second padding block: zeros, with the bit length added in ST_PAD.
            extra_q <= 1'b0;
            for (int i = 0; i < 14; i++) w_q[i] <= '0;
            state_q <= ST_PAD;
          end else if (final_q) begin
            widx_q  <= '0;
            state_q <= ST_EMIT;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (out_ready_i) begin
            widx_q <= widx_q + 3'd1;
            if (widx_q == 3'd7) begin
              for (int i = 0; i < 8; i++) h_q[i] <= InitHash[255-32*i -: 32];
              fill_q  <= '0;
              msg_q   <= '0;
              final_q <= 1'b0;
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end
endmodule

@@ rtl/sha256_byte_stream_hasher_top.sv @@
// Absorb takes a byte only while the core is idle; every 64th byte starts a
// 64-round compression, one round per cycle.
// Finish pads and compresses one or two blocks, then emits eight digest words,
// one per cycle while the sink is ready.
// Input items wait in a four-entry queue while the core compresses.
// Reset (asynchronous, active low) loads the initial hash and clears all counts.
module sha256_byte_stream_hasher_top #(
  parameter int unsigned QueueDepth = sha256_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sha256_in_if.sink   in_if,
  sha256_out_if.source out_if
);
  import sha256_pkg::*;

  logic     q_full, q_empty, q_pop;
  in_item_t q_item;

  assign in_if.ready = !q_full;

  sha256_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni,
    .push_i(in_if.valid), .push_item_i(in_if.payload), .full_o(q_full),
    .pop_i(q_pop), .empty_o(q_empty), .pop_item_o(q_item)
  );

  sha256_core u_core (
    .clk_i, .rst_ni,
    .item_valid_i(!q_empty), .item_i(q_item), .item_pop_o(q_pop),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready), .out_item_o(out_if.payload)
  );
endmodule

@@ bench/tb_sha256_byte_stream_hasher_top.sv @@
// Testbench for the SHA-256 byte-stream hasher: directed and random byte messages checked against a predictor.
module tb_sha256_byte_stream_hasher_top;
  import sha256_pkg::*;

  logic clk_i;
  logic rst_ni;

  sha256_in_if  in_if ();
  sha256_out_if out_if ();

  sha256_byte_stream_hasher_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .out_if (out_if.source)
  );

  localparam logic [31:0] RoundConst [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Predictor state.
  logic [31:0]          hash_state [8];
  logic [7:0]           block_buf [64];
  logic [6:0]           buf_fill;
  logic [MsgBytesW-1:0] hashed_bytes;

  in_item_t  pending_items [$];
  out_item_t digest_queue [$];
  int        error_count;

  function automatic logic [31:0] ror32(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress_buf();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2, s0, s1;
    for (int i = 0; i < 16; i++)
      w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = s1 + w[i-7] + s0 + w[i-16];
    end
    v = hash_state;
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[i] + w[i];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] += v[i];
  endtask

  task automatic restart_hash();
    for (int i = 0; i < 8; i++) hash_state[i] = InitHash[255-32*i -: 32];
    buf_fill = '0;
    hashed_bytes = '0;
  endtask

  task automatic predict_digest(in_item_t item);
    logic [63:0] bit_len;
    int          pos;
    out_item_t   word;
    if (op_e'(item.op) == OP_ABSORB) begin
      block_buf[buf_fill[5:0]] = item.data_byte;
      buf_fill = buf_fill + 7'd1;
      if (buf_fill >= 7'd64) begin
        compress_buf();
        buf_fill = '0;
        hashed_bytes = hashed_bytes + MsgBytesW'(64);
      end
      return;
    end
    hashed_bytes = hashed_bytes + MsgBytesW'(buf_fill[5:0]);
    bit_len = {3'b000, hashed_bytes} << 3;
    pos = buf_fill[5:0];
    block_buf[pos++] = PadMarker;
    if (pos > LenOffset) begin
      while (pos < 64) block_buf[pos++] = 8'h00;
      compress_buf();
      pos = 0;
    end
    while (pos < LenOffset) block_buf[pos++] = 8'h00;
    for (int i = 0; i < 8; i++) block_buf[56+i] = bit_len[63-8*i -: 8];
    compress_buf();
    for (int i = 0; i < 8; i++) begin
      word.digest_word = hash_state[i];
      word.word_index  = 3'(i);
      word.last_word   = (i == 7);
      digest_queue.push_back(word);
    end
    restart_hash();
  endtask

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    error_count++;
  endtask

  task automatic add_message(int len, bit fixed, logic [7:0] fill);
    in_item_t item;
    for (int i = 0; i < len; i++) begin
      item.op = OP_ABSORB;
      item.data_byte = fixed ? fill : 8'($urandom);
      pending_items.push_back(item);
    end
    item.op = OP_FINISH;
    item.data_byte = 8'($urandom);
    pending_items.push_back(item);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    int total;
    int len;
    error_count = 0;
    restart_hash();
    rst_ni = 1'b0;
    // Directed: empty message, two finishes in a row, the padding edges 55/56/63/64
    // bytes, and extreme byte values.
    add_message(0, 1, 8'h00);
    add_message(0, 1, 8'hff);
    add_message(1, 1, 8'h00);
    add_message(3, 1, 8'hff);
    add_message(55, 1, 8'hff);
    add_message(56, 0, 8'h00);
    add_message(63, 0, 8'h00);
    add_message(64, 1, 8'h00);
    total = pending_items.size();
    while (total < 500) begin
      case ($urandom_range(0, 3))
        0: len = $urandom_range(0, 8);
        1: len = $urandom_range(52, 70);
        2: len = $urandom_range(118, 130);
        default: len = $urandom_range(0, 40);
      endcase
      add_message(len, 0, 8'h00);
      total += len + 1;
    end
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    wait (pending_items.size() == 0);
    wait (digest_queue.size() == 0);
    repeat (200) @(posedge clk_i);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  // Driver: bursts of transfers separated by random gaps.
  int burst_left;
  int gap_left;
  bit in_fire;

  // Ready sampled at the rising edge decides whether the current item moved.
  always @(posedge clk_i) begin
    in_fire = rst_ni && in_if.valid && in_if.ready;
    if (in_fire) begin
      predict_digest(pending_items.pop_front());
    end
  end

  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid   <= 1'b0;
      in_if.payload <= '0;
      burst_left = 0;
      gap_left = 0;
    end else if (!in_if.valid || in_fire) begin
      if (gap_left > 0) begin
        gap_left--;
        in_if.valid <= 1'b0;
      end else if (pending_items.size() == 0) begin
        in_if.valid <= 1'b0;
      end else begin
        in_if.valid   <= 1'b1;
        in_if.payload <= pending_items[0];
        if (burst_left == 0) burst_left = $urandom_range(1, 40);
        burst_left--;
        if (burst_left == 0) gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end
    end
  end

  // Monitor and receiver stall pattern.
  int stall_phase;
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_phase = 0;
    end else begin
      stall_phase = (stall_phase + 1) % 97;
      if (stall_phase < 30) out_if.ready <= 1'b1;
      else out_if.ready <= ($urandom_range(0, 2) != 0);
    end
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (digest_queue.size() == 0) begin
        report_mismatch("digest word with none expected");
      end else begin
        want = digest_queue.pop_front();
        if (out_if.payload.digest_word !== want.digest_word)
          report_mismatch($sformatf("digest_word %h, want %h",
                                    out_if.payload.digest_word, want.digest_word));
        if (out_if.payload.word_index !== want.word_index)
          report_mismatch($sformatf("word_index %0d, want %0d",
                                    out_if.payload.word_index, want.word_index));
        if (out_if.payload.last_word !== want.last_word)
          report_mismatch($sformatf("last_word %b, want %b",
                                    out_if.payload.last_word, want.last_word));
      end
    end
  end

endmodule
